### hw/rtl/vcac_pkg.sv
// Shared types and constants for the custom-alphabet Vigenere cipher unit.
// Opcodes, register indexes, character constants and the lookup-table structs.
// No dependencies.
package vcac_pkg;

	// Input word opcodes
	localparam logic [1:0] OP_ALPHA = 2'd0;
	localparam logic [1:0] OP_KEY   = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_ALPHA_SIZE   = 2'd0;
	localparam logic [1:0] REG_KEY_LENGTH   = 2'd1;
	localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

	// Configuration reset values
	localparam logic [6:0] ALPHA_SIZE_RST = 7'd26;
	localparam logic [6:0] KEY_LENGTH_RST = 7'd1;

	// Character constants
	localparam logic [7:0] CH_LOWER_A   = 8'd97;
	localparam logic [7:0] CH_LOWER_END = 8'd123;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;
	localparam logic [7:0] CH_ASTERISK  = 8'd42;

	// Write into the reverse table: character -> alphabet position
	typedef struct packed {
		logic       we;
		logic [7:0] ch;
		logic [5:0] pos;
	} rev_wr_t;

	// Registered read from the reverse table
	typedef struct packed {
		logic       present;
		logic [5:0] pos;
	} rev_rd_t;

	// One result word
	typedef struct packed {
		logic [7:0] char_out;
		logic       unknown_symbol;
	} out_word_t;

	// Uppercase a..z, pass everything else
	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic is_lower;
		is_lower = (c >= CH_LOWER_A) && (c < CH_LOWER_END);
		to_upper = is_lower ? (c - CASE_OFFSET) : c;
	endfunction

endpackage

### hw/rtl/vcac_if.sv
// Valid/ready channel interfaces for the cipher unit: input words and result words.
// Depends on nothing; field widths follow the cipher word format.
interface vcac_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [5:0] slot;
	logic [7:0] char_in;
	logic       start_of_message;

	modport source(output valid, opcode, slot, char_in, start_of_message, input ready);
	modport sink(input valid, opcode, slot, char_in, start_of_message, output ready);
endinterface

interface vcac_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       unknown_symbol;

	modport source(output valid, char_out, unknown_symbol, input ready);
	modport sink(input valid, char_out, unknown_symbol, output ready);
endinterface

### hw/rtl/vcac_rev_lut.sv
// Reverse lookup table: character code -> alphabet position, 256 entries.
// One write port and two registered read ports; per-entry present bits cleared by reset.
// Depends on vcac_pkg.
module vcac_rev_lut import vcac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  rev_wr_t    wr,
	input  logic [7:0] rd_addr_a,
	input  logic [7:0] rd_addr_b,
	output rev_rd_t    rd_a,
	output rev_rd_t    rd_b
);

	logic [5:0]   pos_mem [256];
	logic [255:0] present_q;
	logic [5:0]   pos_a_q;
	logic [5:0]   pos_b_q;
	logic         present_a_q;
	logic         present_b_q;

	// Position storage: write then registered reads, old data on a same-edge hit
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr.we) begin
				pos_mem[wr.ch] <= wr.pos;
			end
			pos_a_q <= pos_mem[rd_addr_a];
			pos_b_q <= pos_mem[rd_addr_b];
		end
	end

	// Present bits: an entry never loaded reads as absent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			present_a_q <= 1'b0;
			present_b_q <= 1'b0;
		end else if (en) begin
			if (wr.we) begin
				present_q[wr.ch] <= 1'b1;
			end
			present_a_q <= present_q[rd_addr_a];
			present_b_q <= present_q[rd_addr_b];
		end
	end

	assign rd_a = '{present: present_a_q, pos: pos_a_q};
	assign rd_b = '{present: present_b_q, pos: pos_b_q};

endmodule

### hw/rtl/vigenere_custom_alphabet_cipher_unit.sv
// Top level of the Vigenere cipher over a loadable alphabet.
// Depends on vcac_pkg, vcac_if (vcac_in_if, vcac_out_if) and vcac_rev_lut.
//
// Usage:
//   data_in carries one word per handshake: opcode 0 loads alphabet entry
//   'slot' with char_in, opcode 1 loads key character 'slot', opcode 2
//   enciphers (decrypt_mode 0) or deciphers (decrypt_mode 1) char_in.
//   Loads and opcode 3 give no result; each data word gives one word on
//   data_out: the output character, or '*' with unknown_symbol set when the
//   data or key character is not in the alphabet.
//   start_of_message on a data word restarts the key at position zero.
//   The cfg port (cfg_we, cfg_idx, cfg_data) writes alpha_size, key_length and
//   decrypt_mode; write only while no word is in flight.
// Timing:
//   Three-stage pipeline (key read, reverse lookup, modular add and alphabet
//   read) feeding a two-entry output buffer whose first entry is the result
//   register. One word is accepted every cycle while the second buffer entry
//   is empty and data_in.ready is high.
//   When data_out stalls, the second buffer entry catches the word in flight
//   and data_in.ready drops until that entry drains.
// Reset:
//   arst_n clears the pipeline, the output buffer, the key position, the
//   reverse table present bits and loads the register defaults (alpha_size 26,
//   key_length 1, encrypt). No clearing pass; words are taken right away.
module vigenere_custom_alphabet_cipher_unit import vcac_pkg::*; #(
	parameter int ALPHA_MAX = 64,
	parameter int KEY_MAX   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [6:0]        cfg_data,
	vcac_in_if.sink           data_in,
	vcac_out_if.source        data_out
);

	localparam int AAW  = $clog2(ALPHA_MAX);
	localparam int KAW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int ALIM = (ALPHA_MAX < 127) ? ALPHA_MAX : 127;
	localparam int KLIM = (KEY_MAX < 64) ? KEY_MAX : 64;

	// Configuration
	logic [6:0] alpha_size_q;
	logic [6:0] key_length_q;
	logic       decrypt_mode_q;
	logic [6:0] n_eff;
	logic [6:0] klen_raw;
	logic [6:0] klen;

	// Front end
	logic       en;
	logic       acc;
	logic       key_slot_ok;
	logic       alpha_slot_ok;
	logic [5:0] kpos_q;
	logic [5:0] kp;
	logic [6:0] kp_inc;
	logic [5:0] kpos_next;
	logic [7:0] key_mem [KEY_MAX];

	// Pipeline
	logic       wa_s1, dat_s1;
	logic [5:0] slot_s1;
	logic [7:0] ch_s1;
	logic [7:0] key_s1;
	logic       wa_s2, dat_s2;
	logic [5:0] slot_s2;
	logic [7:0] ch_s2;
	rev_wr_t    rev_wr;
	rev_rd_t    rd_d_s2;
	rev_rd_t    rd_k_s2;
	logic [7:0] pd, pk, nx;
	logic [7:0] sum, enc_pos, dec_pos, res_pos;
	logic       bad_c;
	logic [7:0] alpha_mem [ALPHA_MAX];
	logic       dat_s3;
	logic       bad_s3;
	logic [7:0] alpha_s3;

	// Output buffer
	out_word_t  res_word;
	out_word_t  od_q, sd_q;
	logic       ov_q, sv_q;
	logic       push, pop;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_size_q   <= ALPHA_SIZE_RST;
			key_length_q   <= KEY_LENGTH_RST;
			decrypt_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ALPHA_SIZE:   alpha_size_q   <= cfg_data;
				REG_KEY_LENGTH:   key_length_q   <= cfg_data;
				REG_DECRYPT_MODE: decrypt_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp sizes to what the stores hold
	always_comb begin
		n_eff    = (alpha_size_q > 7'(ALIM)) ? 7'(ALIM) : alpha_size_q;
		klen_raw = (key_length_q > 7'(KLIM)) ? 7'(KLIM) : key_length_q;
		klen     = (klen_raw == 7'd0) ? 7'd1 : klen_raw;
	end

	assign en            = !sv_q;
	assign data_in.ready = en;
	assign acc           = data_in.valid && en;
	assign key_slot_ok   = 9'(data_in.slot) < 9'(KEY_MAX);
	assign alpha_slot_ok = 9'(data_in.slot) < 9'(ALPHA_MAX);

	// Key position: restart on message start or when out of range, then advance
	always_comb begin
		kp        = (data_in.start_of_message || ({1'b0, kpos_q} >= klen)) ? 6'd0 : kpos_q;
		kp_inc    = {1'b0, kp} + 7'd1;
		kpos_next = (kp_inc >= klen) ? 6'd0 : kp_inc[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kpos_q <= 6'd0;
		end else if (acc && data_in.opcode == OP_DATA) begin
			kpos_q <= kpos_next;
		end
	end

	// Key store: load and read at acceptance
	always_ff @(posedge clk) begin
		if (en) begin
			if (data_in.valid && data_in.opcode == OP_KEY && key_slot_ok) begin
				key_mem[KAW'(data_in.slot)] <= data_in.char_in;
			end
			key_s1 <= key_mem[KAW'(kp)];
		end
	end

	// Stage 1, 2 and 3 controls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_s1  <= 1'b0;
			dat_s1 <= 1'b0;
			wa_s2  <= 1'b0;
			dat_s2 <= 1'b0;
			dat_s3 <= 1'b0;
		end else if (en) begin
			wa_s1  <= acc && data_in.opcode == OP_ALPHA && alpha_slot_ok;
			dat_s1 <= acc && data_in.opcode == OP_DATA;
			wa_s2  <= wa_s1;
			dat_s2 <= dat_s1;
			dat_s3 <= dat_s2;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1 <= data_in.slot;
			ch_s1   <= data_in.char_in;
			slot_s2 <= slot_s1;
			ch_s2   <= ch_s1;
		end
	end

	// Reverse lookup of data and key characters; alphabet loads write here
	assign rev_wr = '{we: wa_s1, ch: ch_s1, pos: slot_s1};

	vcac_rev_lut u_rev_lut (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.wr        (rev_wr),
		.rd_addr_a (to_upper(ch_s1)),
		.rd_addr_b (to_upper(key_s1)),
		.rd_a      (rd_d_s2),
		.rd_b      (rd_k_s2)
	);

	// Modular add or subtract of the two positions
	always_comb begin
		pd      = {2'b00, rd_d_s2.pos};
		pk      = {2'b00, rd_k_s2.pos};
		nx      = {1'b0, n_eff};
		bad_c   = !rd_d_s2.present || !rd_k_s2.present || (pd >= nx) || (pk >= nx);
		sum     = pd + pk;
		enc_pos = (sum >= nx) ? (sum - nx) : sum;
		dec_pos = (pd >= pk) ? (pd - pk) : (pd + nx - pk);
		res_pos = decrypt_mode_q ? dec_pos : enc_pos;
	end

	// Alphabet store: load and read in stage 2
	always_ff @(posedge clk) begin
		if (en) begin
			if (wa_s2) begin
				alpha_mem[AAW'(slot_s2)] <= ch_s2;
			end
			alpha_s3 <= alpha_mem[AAW'(res_pos)];
			bad_s3   <= bad_c;
		end
	end

	// Result word
	assign res_word = '{char_out: bad_s3 ? CH_ASTERISK : alpha_s3, unknown_symbol: bad_s3};
	assign push     = en && dat_s3;
	assign pop      = ov_q && data_out.ready;

	// Output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (pop) begin
			if (sv_q) begin
				sv_q <= 1'b0;
			end else if (!push) begin
				ov_q <= 1'b0;
			end
		end else if (push) begin
			if (!ov_q) begin
				ov_q <= 1'b1;
			end else begin
				sv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (sv_q) begin
				od_q <= sd_q;
			end else if (push) begin
				od_q <= res_word;
			end
		end else if (push) begin
			if (!ov_q) begin
				od_q <= res_word;
			end else begin
				sd_q <= res_word;
			end
		end
	end

	assign data_out.valid          = ov_q;
	assign data_out.char_out       = od_q.char_out;
	assign data_out.unknown_symbol = od_q.unknown_symbol;

	// Skid entry is only ever filled behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid entry holds a word while output register is empty");

	// Skid entry fills only from a stalled output
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sv_q) |-> $past(ov_q && !data_out.ready))
		else $error("skid entry filled without an output stall");

	// Failed lookups always show an asterisk
	a_unknown_asterisk: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && od_q.unknown_symbol) |-> (od_q.char_out == CH_ASTERISK))
		else $error("unknown symbol flagged without asterisk");

	// Key position stays inside the key store range
	a_kpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, kpos_q} < 7'(KLIM))
		else $error("key position beyond key store");

endmodule

### sim/vigenere_custom_alphabet_cipher_unit_tb.sv
// Self-checking testbench for the Vigenere cipher unit over a loadable alphabet.
// Drives load and data words through vcac_in_if, checks result words on vcac_out_if
// against a cycle-free predictor; depends on vcac_pkg, vcac_if and the unit itself.
module vigenere_custom_alphabet_cipher_unit_tb;
	import vcac_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam logic [6:0] ABSENT_POS  = 7'd127;
	localparam int         TABLE_DEPTH = 64;
	localparam int         SETTLE_CYCLES = 10;
	localparam int         QUIET_LIMIT = 2000;

	typedef struct {
		logic [1:0] op;
		logic [5:0] slot;
		logic [7:0] ch;
		logic       som;
	} cipher_req_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [6:0] cfg_data;

	vcac_in_if  plain_if();
	vcac_out_if cipher_if();

	vigenere_custom_alphabet_cipher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.data_in  (plain_if),
		.data_out (cipher_if)
	);

	// Predictor state and register shadow
	logic [7:0] alpha_tab [TABLE_DEPTH];
	logic [6:0] rev_tab   [256];
	logic [7:0] key_tab   [TABLE_DEPTH];
	int         key_pos;
	logic [6:0] cfg_alpha;
	logic [6:0] cfg_klen;
	logic       cfg_decrypt;

	// Alphabet as seen by the stimulus side, updated when loads are queued
	logic [7:0] gen_alpha [TABLE_DEPTH];

	cipher_req_t pending_words[$];
	out_word_t   expected_words[$];
	cipher_req_t next_req;

	bit idle_on;
	int send_gap;
	int recv_stall;
	int quiet_cycles;
	int fail_count;
	int words_accepted;
	int data_words;
	int words_checked;
	int unknown_count;
	int settings_run;

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	function automatic logic [7:0] upcase(input logic [7:0] c);
		if (c >= 8'd97 && c < 8'd123)
			return c - 8'd32;
		return c;
	endfunction

	// Initial alphabet: letters, digits, then punctuation; all distinct
	function automatic logic [7:0] base_char(input int i);
		if (i < 26)
			return 8'(65 + i);
		if (i < 36)
			return 8'(48 + i - 26);
		if (i < 51)
			return 8'(33 + i - 36);
		if (i < 58)
			return 8'(58 + i - 51);
		return 8'(91 + i - 58);
	endfunction

	function automatic int clamp_alpha();
		return (cfg_alpha > 7'd64) ? 64 : int'(cfg_alpha);
	endfunction

	// Advance the cipher state for one accepted word and queue the result of a data word
	task automatic predict_word(input logic [1:0] op, input logic [5:0] slot,
			input logic [7:0] ch, input logic som);
		out_word_t w;
		int n, klen, pd, pk, c;
		if (op == OP_ALPHA) begin
			alpha_tab[slot] = ch;
			rev_tab[ch] = {1'b0, slot};
		end else if (op == OP_KEY) begin
			key_tab[slot] = ch;
		end else if (op == OP_DATA) begin
			n = clamp_alpha();
			klen = (cfg_klen > 7'd64) ? 64 : int'(cfg_klen);
			if (klen == 0)
				klen = 1;
			if (som || key_pos >= klen)
				key_pos = 0;
			pd = rev_tab[upcase(ch)];
			pk = rev_tab[upcase(key_tab[key_pos])];
			if (pd >= n || pk >= n) begin
				w.char_out = CH_ASTERISK;
				w.unknown_symbol = 1'b1;
				unknown_count++;
			end else begin
				if (cfg_decrypt)
					c = (pd >= pk) ? pd - pk : pd + n - pk;
				else begin
					c = pd + pk;
					if (c >= n)
						c -= n;
				end
				w.char_out = alpha_tab[c];
				w.unknown_symbol = 1'b0;
			end
			key_pos++;
			if (key_pos >= klen)
				key_pos = 0;
			expected_words.push_back(w);
			data_words++;
		end
	endtask

	// Compare one result word with the oldest expectation
	task automatic check_word(input logic [7:0] ch, input logic unk);
		out_word_t w;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected result word char_out=%02h unknown_symbol=%b",
				$realtime, ch, unk);
			fail_count++;
		end else begin
			w = expected_words.pop_front();
			words_checked++;
			if (ch !== w.char_out || unk !== w.unknown_symbol) begin
				$display("%0t: mismatch expected char_out=%02h unknown_symbol=%b, got %02h %b",
					$realtime, w.char_out, w.unknown_symbol, ch, unk);
				fail_count++;
			end
		end
	endtask

	// Driver: hold a word until taken, insert random idle bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			plain_if.valid <= 1'b0;
		end else begin
			if (plain_if.valid && plain_if.ready) begin
				predict_word(plain_if.opcode, plain_if.slot, plain_if.char_in,
					plain_if.start_of_message);
				words_accepted++;
			end
			if (!plain_if.valid || plain_if.ready) begin
				if (idle_on && send_gap > 0) begin
					plain_if.valid <= 1'b0;
					send_gap--;
				end else if (pending_words.size() > 0) begin
					next_req = pending_words.pop_front();
					plain_if.valid <= 1'b1;
					plain_if.opcode <= next_req.op;
					plain_if.slot <= next_req.slot;
					plain_if.char_in <= next_req.ch;
					plain_if.start_of_message <= next_req.som;
					if (idle_on && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 18);
				end else begin
					plain_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check taken result words, stall ready in random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			cipher_if.ready <= 1'b0;
		end else begin
			if (cipher_if.valid && cipher_if.ready)
				check_word(cipher_if.char_out, cipher_if.unknown_symbol);
			if (idle_on && recv_stall > 0) begin
				cipher_if.ready <= 1'b0;
				recv_stall--;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				cipher_if.ready <= 1'b0;
				recv_stall = $urandom_range(0, 17);
			end else begin
				cipher_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when neither side moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (plain_if.valid && plain_if.ready) ||
				(cipher_if.valid && cipher_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: timeout, %0d words pending, %0d results outstanding",
					$realtime, pending_words.size(), expected_words.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic push_word(input logic [1:0] op, input logic [5:0] slot,
			input logic [7:0] ch, input logic som);
		cipher_req_t r;
		r.op = op;
		r.slot = slot;
		r.ch = ch;
		r.som = som;
		if (op == OP_ALPHA)
			gen_alpha[slot] = ch;
		pending_words.push_back(r);
	endtask

	task automatic push_data(input logic [7:0] ch, input logic som);
		push_word(OP_DATA, 6'($urandom_range(0, 63)), ch, som);
	endtask

	// Mostly alphabet characters (sometimes lowercased), else any byte
	function automatic logic [7:0] pick_char(input int n);
		logic [7:0] c;
		if (n > 0 && $urandom_range(0, 9) < 7) begin
			c = gen_alpha[$urandom_range(0, n - 1)];
			if (c >= 8'd65 && c <= 8'd90 && $urandom_range(0, 1))
				c = c + 8'd32;
		end else begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	// Mostly data words, with some reloads of alphabet and key and a few unused opcodes
	task automatic push_random_word();
		int pick, n;
		logic [7:0] c;
		logic [5:0] s;
		logic som;
		n = clamp_alpha();
		pick = $urandom_range(0, 99);
		s = 6'($urandom_range(0, 63));
		som = ($urandom_range(0, 9) == 0);
		if (pick < 5) begin
			c = ($urandom_range(0, 9) < 7) ? base_char($urandom_range(0, 63))
				: 8'($urandom_range(0, 255));
			push_word(OP_ALPHA, s, c, som);
		end else if (pick < 10) begin
			push_word(OP_KEY, s, pick_char(n), som);
		end else if (pick < 13) begin
			push_word(OP_UNUSED, s, 8'($urandom_range(0, 255)), som);
		end else begin
			push_word(OP_DATA, s, pick_char(n), som);
		end
	endtask

	// Wait until every word is taken and every result has arrived, then settle
	task automatic drain();
		@(posedge clk);
		while (pending_words.size() != 0 || plain_if.valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_ALPHA_SIZE:   cfg_alpha = val;
			REG_KEY_LENGTH:   cfg_klen = val;
			REG_DECRYPT_MODE: cfg_decrypt = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One register setting: program, then random words with a full pause halfway
	task automatic run_setting(input logic [6:0] alpha, input logic [6:0] klen,
			input logic dec, input int count, input bit idle);
		write_reg(REG_ALPHA_SIZE, alpha);
		write_reg(REG_KEY_LENGTH, klen);
		write_reg(REG_DECRYPT_MODE, {6'd0, dec});
		idle_on = idle;
		settings_run++;
		repeat (count / 2) push_random_word();
		drain();
		repeat (count - count / 2) push_random_word();
		drain();
	endtask

	initial begin
		// Reset state of the predictor and known values on every input
		for (int i = 0; i < 256; i++)
			rev_tab[i] = ABSENT_POS;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			alpha_tab[i] = 8'd0;
			key_tab[i] = 8'd0;
			gen_alpha[i] = 8'd0;
		end
		key_pos = 0;
		cfg_alpha = ALPHA_SIZE_RST;
		cfg_klen = KEY_LENGTH_RST;
		cfg_decrypt = 1'b0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_ALPHA_SIZE;
		cfg_data = 7'd0;
		plain_if.valid = 1'b0;
		plain_if.opcode = OP_DATA;
		plain_if.slot = 6'd0;
		plain_if.char_in = 8'd0;
		plain_if.start_of_message = 1'b0;
		cipher_if.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill every alphabet and key slot so no unwritten entry is ever read
		for (int i = 0; i < TABLE_DEPTH; i++)
			push_word(OP_ALPHA, 6'(i), base_char(i), 1'b0);
		for (int i = 0; i < TABLE_DEPTH; i++)
			push_word(OP_KEY, 6'(i), (i % 3 == 0) ? 8'(97 + (i * 7) % 26)
				: 8'(65 + (i * 5) % 26), 1'b1);

		// Directed words under reset settings: 26 symbols, key length one, encrypt
		push_data("A", 1'b1);
		push_data("z", 1'b0);
		push_data("m", 1'b0);
		push_data(8'h00, 1'b0);
		push_data(8'hFF, 1'b1);
		push_data(8'd96, 1'b0);
		push_data(8'd123, 1'b0);
		// key character missing from the alphabet
		push_word(OP_KEY, 6'd0, 8'hFF, 1'b0);
		push_data("B", 1'b0);
		push_word(OP_KEY, 6'd0, "q", 1'b1);
		push_data("K", 1'b1);
		// overwrite an entry: the old character keeps its stale reverse entry
		push_word(OP_ALPHA, 6'd2, "Q", 1'b0);
		push_data("C", 1'b0);
		push_data("q", 1'b0);
		push_word(OP_ALPHA, 6'd2, "C", 1'b0);
		push_data("Q", 1'b0);
		push_word(OP_ALPHA, 6'd16, "Q", 1'b0);
		// unused opcode is dropped
		push_word(OP_UNUSED, 6'd63, 8'hFF, 1'b1);
		push_word(OP_ALPHA, 6'd63, 8'hE0, 1'b1);
		push_word(OP_KEY, 6'd63, "Z", 1'b0);
		push_data(8'hE0, 1'b0);
		push_data("9", 1'b0);
		push_data("Z", 1'b1);
		drain();

		// Sweep register settings, extremes included; the last one runs without idling
		run_setting(7'd64, 7'd64, 1'b0, 80, 1'b1);
		run_setting(7'd64, 7'd5, 1'b1, 80, 1'b1);
		run_setting(7'd127, 7'd0, 1'b1, 60, 1'b1);
		run_setting(7'd1, 7'd127, 1'b0, 50, 1'b1);
		run_setting(7'd0, 7'd3, 1'b0, 30, 1'b1);
		write_reg(REG_UNUSED, 7'd127);
		run_setting(7'd37, 7'd13, 1'b1, 80, 1'b1);
		run_setting(7'd26, 7'd64, 1'b0, 70, 1'b0);

		$display("Covered %0d input words (%0d data) over %0d register settings plus reset values;",
			words_accepted, data_words, settings_run);
		$display("checked %0d result words, %0d of them flagged as unknown symbols.",
			words_checked, unknown_count);
		if (fail_count == 0 && expected_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
